[rtl/core/iafd_pkg.sv]
package iafd_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned PAYLOAD_LEN = 6;

    typedef logic [2:0]         t_pos;
    typedef logic [7:0]         t_byte;
    typedef logic [15:0]        t_raw;
    typedef logic signed [16:0] t_angle;
    typedef logic signed [17:0] t_wide;

    // byte positions with special meaning
    localparam t_pos POS_HEAD = 3'd0;
    localparam t_pos POS_TAIL = 3'(FRAME_LEN - 1);

    localparam t_byte FRAME_HEAD = 8'hAA;
    localparam t_byte FRAME_TAIL = 8'h55;

    // angle folding thresholds, centidegrees
    localparam t_raw  FOLD_LIMIT = 16'd17900;
    localparam t_raw  ROLL_FLIP  = 16'd47500;
    localparam t_wide WRAP_BASE  = 18'sd65500;

    // yaw and pitch: negate at or below the fold, else wrap
    function automatic t_angle decode_yp(input t_raw raw);
        t_wide wide;
        t_wide r_ext;
        r_ext = $signed({2'b00, raw});
        if (raw <= FOLD_LIMIT) begin
            wide = -r_ext;
        end else begin
            wide = WRAP_BASE - r_ext;
        end
        return wide[16:0];
    endfunction

    // roll: pass at or below the fold, wrap in the middle, flip above
    function automatic t_angle decode_roll(input t_raw raw);
        t_wide wide;
        t_wide r_ext;
        r_ext = $signed({2'b00, raw});
        if (raw <= FOLD_LIMIT) begin
            wide = r_ext;
        end else if (raw > ROLL_FLIP) begin
            wide = r_ext - WRAP_BASE;
        end else begin
            wide = WRAP_BASE - r_ext;
        end
        return wide[16:0];
    endfunction

endpackage

[rtl/core/imu_angle_frame_decoder_top.sv]
// A result word is presented in the cycle after its tail byte is accepted.
// Throughput: one byte per cycle; at most one result per eight-byte frame.
// The input stalls only when a tail byte waits while the result register is
// still full and stalled downstream.
// Reset (synchronous, active low) returns to header search and empties the output.
module imu_angle_frame_decoder_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  iafd_pkg::t_byte       i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output iafd_pkg::t_angle      o_yaw_centideg,
    output iafd_pkg::t_angle      o_pitch_centideg,
    output iafd_pkg::t_angle      o_roll_centideg
);

    iafd_pkg::t_pos   r_pos;
    iafd_pkg::t_pos   n_pos;
    iafd_pkg::t_byte  r_payload [iafd_pkg::PAYLOAD_LEN];
    logic             r_out_valid;
    iafd_pkg::t_angle r_yaw;
    iafd_pkg::t_angle r_pitch;
    iafd_pkg::t_angle r_roll;

    logic w_accept;
    logic w_emit;
    logic w_take;

    // hold a tail byte only if the result register cannot take it
    assign o_stall  = (r_pos == iafd_pkg::POS_TAIL) && r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_take   = r_out_valid && !i_stall;
    assign w_emit   = w_accept && (r_pos == iafd_pkg::POS_TAIL)
                      && (i_rx_byte == iafd_pkg::FRAME_TAIL);

    // advance frame position
    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            if (r_pos == iafd_pkg::POS_HEAD) begin
                if (i_rx_byte == iafd_pkg::FRAME_HEAD) begin
                    n_pos = r_pos + 3'd1;
                end
            end else if (r_pos == iafd_pkg::POS_TAIL) begin
                n_pos = iafd_pkg::POS_HEAD;
            end else begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= iafd_pkg::POS_HEAD;
        end else begin
            r_pos <= n_pos;
        end
    end

    // store payload bytes
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_pos != iafd_pkg::POS_HEAD) && (r_pos != iafd_pkg::POS_TAIL)) begin
            r_payload[r_pos - 3'd1] <= i_rx_byte;
        end
    end

    // result register: drop on take, load on a good tail
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_yaw   <= iafd_pkg::decode_yp({r_payload[0], r_payload[1]});
            r_pitch <= iafd_pkg::decode_yp({r_payload[2], r_payload[3]});
            r_roll  <= iafd_pkg::decode_roll({r_payload[4], r_payload[5]});
        end
    end

    assign o_valid          = r_out_valid;
    assign o_yaw_centideg   = r_yaw;
    assign o_pitch_centideg = r_pitch;
    assign o_roll_centideg  = r_roll;

`ifndef SYNTHESIS
    a_stall_only_at_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_pos == iafd_pkg::POS_TAIL))
        else $error("input stalled away from the tail position");

    a_new_result_from_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |->
            $past(i_valid && !o_stall && (r_pos == iafd_pkg::POS_TAIL)))
        else $error("result appeared without an accepted tail byte");

    a_tail_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_pos == iafd_pkg::POS_TAIL)) |=> (r_pos == iafd_pkg::POS_HEAD))
        else $error("frame position did not restart after the tail");

    a_noise_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_pos == iafd_pkg::POS_HEAD) && (i_rx_byte != iafd_pkg::FRAME_HEAD))
            |=> (r_pos == iafd_pkg::POS_HEAD))
        else $error("non-header word left header search");
`endif

endmodule

[verif/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // decoded angles carried by one result word
    typedef struct packed {
        iafd_pkg::t_angle yaw;
        iafd_pkg::t_angle pitch;
        iafd_pkg::t_angle roll;
    } t_angles;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    iafd_pkg::t_byte  i_rx_byte = '0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    iafd_pkg::t_angle o_yaw_centideg;
    iafd_pkg::t_angle o_pitch_centideg;
    iafd_pkg::t_angle o_roll_centideg;

    // shadow copy of the frame assembler
    iafd_pkg::t_pos  frame_pos = iafd_pkg::POS_HEAD;
    iafd_pkg::t_byte frame_bytes [iafd_pkg::PAYLOAD_LEN];
    t_angles         pending_angles [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_errors = 0;

    // raw words at the extremes and right at and around the folding thresholds
    iafd_pkg::t_raw corner_raw [12] = '{16'd0, 16'd1, 16'd17899, 16'd17900, 16'd17901,
                                        16'd47499, 16'd47500, 16'd47501, 16'd65499,
                                        16'd65500, 16'd65501, 16'd65535};

    imu_angle_frame_decoder_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_yaw_centideg   (o_yaw_centideg),
        .o_pitch_centideg (o_pitch_centideg),
        .o_roll_centideg  (o_roll_centideg)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // yaw and pitch: negate up to the fold limit, wrap from the base above it
    function automatic iafd_pkg::t_angle fold_yaw_pitch(input iafd_pkg::t_raw raw);
        int v;
        if (int'(raw) <= int'(iafd_pkg::FOLD_LIMIT)) begin
            v = -int'(raw);
        end else begin
            v = int'(iafd_pkg::WRAP_BASE) - int'(raw);
        end
        return iafd_pkg::t_angle'(v);
    endfunction

    // roll: pass up to the fold limit, wrap in the middle band, flip sign above
    function automatic iafd_pkg::t_angle fold_roll(input iafd_pkg::t_raw raw);
        int v;
        if (int'(raw) <= int'(iafd_pkg::FOLD_LIMIT)) begin
            v = int'(raw);
        end else if (int'(raw) > int'(iafd_pkg::ROLL_FLIP)) begin
            v = int'(raw) - int'(iafd_pkg::WRAP_BASE);
        end else begin
            v = int'(iafd_pkg::WRAP_BASE) - int'(raw);
        end
        return iafd_pkg::t_angle'(v);
    endfunction

    // advance the shadow assembler by one accepted word
    task automatic track_byte(input iafd_pkg::t_byte b);
        t_angles a;
        if (frame_pos == iafd_pkg::POS_HEAD) begin
            if (b == iafd_pkg::FRAME_HEAD) begin
                frame_pos = 3'd1;
            end
        end else if (frame_pos != iafd_pkg::POS_TAIL) begin
            frame_bytes[frame_pos - 3'd1] = b;
            frame_pos = frame_pos + 3'd1;
        end else begin
            frame_pos = iafd_pkg::POS_HEAD;
            if (b == iafd_pkg::FRAME_TAIL) begin
                a.yaw   = fold_yaw_pitch({frame_bytes[0], frame_bytes[1]});
                a.pitch = fold_yaw_pitch({frame_bytes[2], frame_bytes[3]});
                a.roll  = fold_roll({frame_bytes[4], frame_bytes[5]});
                pending_angles.push_back(a);
            end
        end
    endtask

    // present one word, hold it through stalls, record it once accepted
    task automatic drive_byte(input iafd_pkg::t_byte b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        track_byte(b);
    endtask

    task automatic drive_frame(input iafd_pkg::t_raw yaw, input iafd_pkg::t_raw pitch,
                               input iafd_pkg::t_raw roll, input iafd_pkg::t_byte tail);
        drive_byte(iafd_pkg::FRAME_HEAD);
        drive_byte(yaw[15:8]);
        drive_byte(yaw[7:0]);
        drive_byte(pitch[15:8]);
        drive_byte(pitch[7:0]);
        drive_byte(roll[15:8]);
        drive_byte(roll[7:0]);
        drive_byte(tail);
    endtask

    function automatic iafd_pkg::t_raw pick_raw();
        if ($urandom_range(1) == 1) begin
            return corner_raw[4'($urandom_range(11))];
        end
        return iafd_pkg::t_raw'($urandom_range(16'hFFFF));
    endfunction

    // compare each accepted result word with the oldest pending angles
    always @(posedge i_clk) begin
        t_angles a;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_angles.size() == 0) begin
                $error("result word with no decoded angles pending");
                n_errors++;
            end else begin
                a = pending_angles.pop_front();
                if (o_yaw_centideg !== a.yaw) begin
                    $error("yaw_centideg: expected %0d, got %0d", a.yaw, o_yaw_centideg);
                    n_errors++;
                end
                if (o_pitch_centideg !== a.pitch) begin
                    $error("pitch_centideg: expected %0d, got %0d", a.pitch,
                           o_pitch_centideg);
                    n_errors++;
                end
                if (o_roll_centideg !== a.roll) begin
                    $error("roll_centideg: expected %0d, got %0d", a.roll, o_roll_centideg);
                    n_errors++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // non-header words while searching must be dropped
    task automatic test_stray_bytes();
        drive_byte(8'h00);
        drive_byte(iafd_pkg::FRAME_TAIL);
    endtask

    // zero, full scale, both sides of the fold limit, just above the roll flip and wrap base
    task automatic test_angle_extremes();
        drive_frame(16'd0, 16'd65535, 16'd17900, iafd_pkg::FRAME_TAIL);
        drive_frame(16'd17901, 16'd65501, 16'd47501, iafd_pkg::FRAME_TAIL);
    endtask

    // header value inside the payload is plain data
    task automatic test_header_in_payload();
        drive_frame(16'hAAAA, 16'hAA55, 16'd47500, iafd_pkg::FRAME_TAIL);
    endtask

    // wrong tail drops the whole frame
    task automatic test_bad_tail();
        drive_frame(16'd65500, 16'd17900, 16'd65535, iafd_pkg::FRAME_HEAD);
    endtask

    // mostly well-formed frames, some broken tails and stray or extra headers
    task automatic test_random_stream(input int n_bytes, input int idle_pct,
                                      input int stall_pct);
        int sent;
        int n_noise;
        iafd_pkg::t_byte b;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(99) < 80) begin
                if ($urandom_range(99) < 85) begin
                    b = iafd_pkg::FRAME_TAIL;
                end else begin
                    do begin
                        b = iafd_pkg::t_byte'($urandom_range(255));
                    end while (b == iafd_pkg::FRAME_TAIL);
                end
                drive_frame(pick_raw(), pick_raw(), pick_raw(), b);
                sent += int'(iafd_pkg::FRAME_LEN);
            end else begin
                n_noise = $urandom_range(1, 3);
                repeat (n_noise) begin
                    if ($urandom_range(3) == 0) begin
                        drive_byte(iafd_pkg::FRAME_HEAD);
                    end else begin
                        drive_byte(iafd_pkg::t_byte'($urandom_range(255)));
                    end
                end
                sent += n_noise;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stray_bytes();
        test_angle_extremes();
        test_header_in_payload();
        test_bad_tail();
        test_random_stream(440, 0, 0);
        test_random_stream(440, 84, 0);
        test_random_stream(440, 0, 84);
        test_random_stream(440, 23, 23);

        // let the last result word drain
        i_valid <= 1'b0;
        while (pending_angles.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);

        if (n_errors == 0 && pending_angles.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // hard stop if the stream hangs
    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
